// ===== sv/grc_pkg.sv =====
// Shared constants and types for the grid ray caster.
`default_nettype none
package grc_pkg;
  localparam int MAP_DIM  = 32;
  localparam int MAP_BITS = $clog2(MAP_DIM);
  localparam int MAP_AW   = 2 * MAP_BITS;
  localparam int MAX_STEPS = 2 * MAP_DIM + 4;
  localparam int STEP_W   = $clog2(MAX_STEPS + 1);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_COLS    = 3'd6;
  localparam logic [2:0] REG_ROWS    = 3'd7;

  typedef struct packed {
    logic       func;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [7:0] cell_value;
    logic [9:0] column;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic [9:0]  draw_start;
    logic [9:0]  draw_end;
    logic [7:0]  wall_type;
    logic        hit_side;
    logic [4:0]  hit_x;
    logic [4:0]  hit_y;
    logic [23:0] perp_dist;
    logic        escaped;
  } out_beat_t;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [39:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== sv/grc_if.sv =====
// Valid/ready channel interfaces for input and result beats.
`default_nettype none
interface grc_in_if;
  logic              valid;
  logic              ready;
  grc_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface grc_out_if;
  logic               valid;
  logic               ready;
  grc_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/grc_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module grc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire grc_pkg::div_req_t req_i,
  output grc_pkg::div_rsp_t      rsp_o
);
  logic [47:0] quot_q, quot_d;
  logic [40:0] rem_q, rem_d;
  logic [39:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [40:0] shifted;

  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[39:0], quot_q[47]};
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 6'd47;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[46:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d     = shifted - {1'b0, den_q};
        quot_d[0] = 1'b1;
      end else begin
        rem_d = shifted;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
endmodule
`default_nettype wire

// ===== sv/grc_map_ram.sv =====
// Map cell store: one write port, one read port, registered read data.
`default_nettype none
module grc_map_ram (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [grc_pkg::MAP_AW-1:0] waddr_i,
  input  wire logic [7:0]                 wdata_i,
  input  wire logic [grc_pkg::MAP_AW-1:0] raddr_i,
  output logic [7:0]                      rdata_o
);
  logic [7:0] mem [grc_pkg::MAP_DIM*grc_pkg::MAP_DIM];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/grid_ray_cast_dda_core.sv =====
// Top level of the grid ray caster: sequencer, map store and shared divider.
// A map write passes through the S_WRITE state. A cast runs one item at a time
// through a single serial divider. The camera coordinate division comes first,
// then the two multiplies. Each step delta is a division, skipped when that ray
// component is zero. The DDA walk then takes one map read per step, for up to
// 2*MAP_DIM+4 steps. The stripe height is a division, skipped when the distance
// is zero. The divider and the map read port set the time per column. A finished
// result waits in an output register, so the next beat is accepted while it
// waits. A cast that finishes while that register is still full holds until the
// register frees. The map has no reset; every cell must be written before a cast
// reads it.
`default_nettype none
module grid_ray_cast_dda_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  grc_in_if.sink           in_if,
  grc_out_if.source        out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [20:0] cfg_data_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_CAM, S_RAY, S_DX, S_DY, S_SIDE, S_STEP,
    S_READ, S_LH, S_FIN, S_OUT
  } state_e;

  state_e state_q;

  logic [20:0] pos_x_q, pos_y_q;
  logic signed [17:0] dir_x_q, dir_y_q, pl_x_q, pl_y_q;
  logic [10:0] cols_q, rows_q;

  grc_pkg::in_beat_t  beat_q;
  grc_pkg::out_beat_t work_q;
  grc_pkg::out_beat_t res_q;
  logic               out_valid_q;

  // Columns past the screen width push the camera coordinate past 1.
  logic signed [27:0] cam_q;
  logic signed [45:0] prx_q, pry_q;
  logic signed [29:0] rx_q, ry_q;
  logic [40:0] dx_q, dy_q;
  logic [45:0] sdx_q, sdy_q;
  logic [63:0] perp_q;
  logic signed [grc_pkg::MAP_BITS+1:0] cx_q, cy_q;
  logic [grc_pkg::STEP_W-1:0] n_q;
  logic side_q;
  logic sub_q;

  grc_pkg::div_req_t div_req;
  grc_pkg::div_rsp_t div_rsp;

  logic [10:0] cols_e, rows_e;
  assign cols_e = (cols_q == '0) ? 11'd1 : cols_q;
  assign rows_e = (rows_q == '0) ? 11'd1 : rows_q;

  logic we;
  logic [grc_pkg::MAP_AW-1:0] raddr;
  logic [7:0] rdata;

  assign we = (state_q == S_WRITE);
  assign raddr = {cy_q[grc_pkg::MAP_BITS-1:0], cx_q[grc_pkg::MAP_BITS-1:0]};

  grc_map_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ({beat_q.cell_y[grc_pkg::MAP_BITS-1:0], beat_q.cell_x[grc_pkg::MAP_BITS-1:0]}),
    .wdata_i (beat_q.cell_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  grc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic out_load;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_if.ready);

  assign in_if.ready  = (state_q == S_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = res_q;

  // Magnitude of a ray component and side-distance helpers.
  logic [29:0] mag_x, mag_y;
  assign mag_x = rx_q[29] ? 30'(-rx_q) : 30'(rx_q);
  assign mag_y = ry_q[29] ? 30'(-ry_q) : 30'(ry_q);

  logic [16:0] part_x, part_y;
  assign part_x = rx_q[29] ? {1'b0, pos_x_q[15:0]} : 17'(17'h10000 - {1'b0, pos_x_q[15:0]});
  assign part_y = ry_q[29] ? {1'b0, pos_y_q[15:0]} : 17'(17'h10000 - {1'b0, pos_y_q[15:0]});

  // A delta is either the infinite marker, a pure power of two, or fits in 33 bits.
  logic [57:0] pm_x, pm_y;
  assign pm_x = dx_q[40] ? 58'({part_x, 40'b0}) : 58'(part_x) * 58'(dx_q[32:0]);
  assign pm_y = dy_q[40] ? 58'({part_y, 40'b0}) : 58'(part_y) * 58'(dy_q[32:0]);

  logic step_x;
  logic signed [grc_pkg::MAP_BITS+1:0] ncx, ncy;
  logic [45:0] nsdx, nsdy;
  logic out_map;
  always_comb begin
    step_x = sdx_q < sdy_q;
    ncx = cx_q;
    ncy = cy_q;
    nsdx = sdx_q;
    nsdy = sdy_q;
    if (step_x) begin
      nsdx = sdx_q + 46'(dx_q);
      ncx  = rx_q[29] ? cx_q - 2'sd1 : cx_q + 2'sd1;
    end else begin
      nsdy = sdy_q + 46'(dy_q);
      ncy  = ry_q[29] ? cy_q - 2'sd1 : cy_q + 2'sd1;
    end
    out_map = ncx < 0 || ncx >= grc_pkg::MAP_DIM || ncy < 0 || ncy >= grc_pkg::MAP_DIM;
  end

  logic [23:0] perp_sat;
  assign perp_sat = (perp_q > 64'hFFFFFF) ? 24'hFFFFFF : perp_q[23:0];

  logic [11:0] half, lh2;
  logic [47:0] lh_full;
  assign half = 12'(rows_e >> 1);
  assign lh_full = (perp_sat == '0) ? 48'(2 * rows_e + 2) : div_rsp.quot;

  logic [9:0]  ds_s, de_s;
  logic [12:0] span_end;
  always_comb begin
    span_end = 13'(half) + 13'(lh2);
    ds_s = (lh2 > half) ? 10'd0 :
           ((half - lh2) > 12'd1023 ? 10'd1023 : 10'(half - lh2));
    if (span_end >= 13'(rows_e))
      de_s = (rows_e - 11'd1 > 11'd1023) ? 10'd1023 : 10'(rows_e - 11'd1);
    else if (span_end > 13'd1023)
      de_s = 10'd1023;
    else
      de_s = 10'(span_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pos_x_q     <= 21'd229376;
      pos_y_q     <= 21'd229376;
      dir_x_q     <= 18'sd65536;
      dir_y_q     <= '0;
      pl_x_q      <= '0;
      pl_y_q      <= 18'sd43254;
      cols_q      <= 11'd740;
      rows_q      <= 11'd580;
      div_req     <= '0;
      sub_q       <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          grc_pkg::REG_POS_X:   pos_x_q <= cfg_data_i;
          grc_pkg::REG_POS_Y:   pos_y_q <= cfg_data_i;
          grc_pkg::REG_DIR_X:   dir_x_q <= cfg_data_i[17:0];
          grc_pkg::REG_DIR_Y:   dir_y_q <= cfg_data_i[17:0];
          grc_pkg::REG_PLANE_X: pl_x_q  <= cfg_data_i[17:0];
          grc_pkg::REG_PLANE_Y: pl_y_q  <= cfg_data_i[17:0];
          grc_pkg::REG_COLS:    cols_q  <= cfg_data_i[10:0];
          grc_pkg::REG_ROWS:    rows_q  <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            beat_q <= in_if.data;
            if (in_if.data.func == grc_pkg::FUNC_WRITE) begin
              state_q <= S_WRITE;
            end else begin
              div_req.start <= 1'b1;
              div_req.num   <= 48'({in_if.data.column, 17'b0});
              div_req.den   <= 40'(cols_e);
              state_q <= S_CAM;
            end
          end
        end
        S_WRITE: state_q <= S_IDLE;
        S_CAM: begin
          if (div_rsp.done) begin
            cam_q <= signed'({1'b0, div_rsp.quot[26:0]}) - 28'sd65536;
            state_q <= S_RAY;
            sub_q <= 1'b0;
          end
        end
        S_RAY: begin
          // The first pass forms the products, the second adds them to the direction.
          if (!sub_q) begin
            prx_q <= 46'(pl_x_q) * 46'(cam_q);
            pry_q <= 46'(pl_y_q) * 46'(cam_q);
            sub_q <= 1'b1;
          end else begin
            rx_q <= 30'(dir_x_q) + 30'(prx_q >>> 16);
            ry_q <= 30'(dir_y_q) + 30'(pry_q >>> 16);
            cx_q <= (grc_pkg::MAP_BITS+2)'(pos_x_q[20:16]);
            cy_q <= (grc_pkg::MAP_BITS+2)'(pos_y_q[20:16]);
            work_q.hit_x <= pos_x_q[20:16];
            work_q.hit_y <= pos_y_q[20:16];
            work_q.hit_side <= 1'b0;
            work_q.wall_type <= '0;
            work_q.escaped <= 1'b0;
            work_q.column_out <= beat_q.column;
            perp_q <= '0;
            n_q <= '0;
            sub_q <= 1'b0;
            if (pos_x_q[20:16] >= grc_pkg::MAP_DIM || pos_y_q[20:16] >= grc_pkg::MAP_DIM) begin
              work_q.escaped <= 1'b1;
              state_q <= S_LH;
            end else begin
              state_q <= S_DX;
            end
          end
        end
        S_DX: begin
          if (!sub_q) begin
            sub_q <= 1'b1;
            if (rx_q == '0) begin
              dx_q <= 41'h100_0000_0000;
              sub_q <= 1'b0;
              state_q <= S_DY;
            end else begin
              div_req.start <= 1'b1;
              div_req.num   <= 48'h1_0000_0000;
              div_req.den   <= 40'(mag_x);
            end
          end else if (div_rsp.done) begin
            dx_q <= 41'(div_rsp.quot[32:0]);
            sub_q <= 1'b0;
            state_q <= S_DY;
          end
        end
        S_DY: begin
          if (!sub_q) begin
            sub_q <= 1'b1;
            if (ry_q == '0) begin
              dy_q <= 41'h100_0000_0000;
              sub_q <= 1'b0;
              state_q <= S_SIDE;
            end else begin
              div_req.start <= 1'b1;
              div_req.num   <= 48'h1_0000_0000;
              div_req.den   <= 40'(mag_y);
            end
          end else if (div_rsp.done) begin
            dy_q <= 41'(div_rsp.quot[32:0]);
            sub_q <= 1'b0;
            state_q <= S_SIDE;
          end
        end
        S_SIDE: begin
          sdx_q <= 46'(pm_x >> 16);
          sdy_q <= 46'(pm_y >> 16);
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (n_q == grc_pkg::STEP_W'(grc_pkg::MAX_STEPS)) begin
            state_q <= S_LH;
          end else begin
            n_q <= n_q + 1'b1;
            sdx_q <= nsdx;
            sdy_q <= nsdy;
            work_q.hit_side <= !step_x;
            perp_q <= 64'(step_x ? sdx_q : sdy_q);
            if (out_map) begin
              work_q.escaped <= 1'b1;
              state_q <= S_LH;
            end else begin
              cx_q <= ncx;
              cy_q <= ncy;
              work_q.hit_x <= ncx[4:0];
              work_q.hit_y <= ncy[4:0];
              state_q <= S_READ;
              sub_q <= 1'b0;
            end
          end
        end
        S_READ: begin
          // Read data arrives in the cycle after the address settles.
          if (!sub_q) begin
            sub_q <= 1'b1;
          end else begin
            sub_q <= 1'b0;
            work_q.wall_type <= rdata;
            state_q <= (rdata != '0) ? S_LH : S_STEP;
          end
        end
        S_LH: begin
          work_q.perp_dist <= perp_sat;
          if (perp_sat == '0) begin
            state_q <= S_FIN;
          end else begin
            div_req.start <= 1'b1;
            div_req.num   <= 48'({rows_e, 16'b0});
            div_req.den   <= 40'(perp_sat);
            state_q <= S_FIN;
            sub_q <= 1'b1;
          end
        end
        S_FIN: begin
          if (!sub_q || div_rsp.done) begin
            sub_q <= 1'b0;
            lh2 <= 12'(lh_full[47:1] > 47'd4095 ? 47'd4095 : lh_full[47:1]);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold here while the previous result still waits in the output register.
          if (out_load) begin
            res_q <= {work_q.column_out, ds_s, de_s, work_q.wall_type, work_q.hit_side,
                      work_q.hit_x, work_q.hit_y, work_q.perp_dist, work_q.escaped};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/grc_checker.sv =====
// Port-level checker for the grid ray caster, bound to the top level.
`default_nettype none
module grc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_escaped,
  input wire logic [7:0] out_wall
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_esc_wall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_escaped |-> out_wall == 8'd0) else $error("escape with wall");
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_wall) && $stable(out_escaped))
    else $error("result changed while waiting");
endmodule

bind grid_ray_cast_dda_core grc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_escaped(out_if.data.escaped), .out_wall(out_if.data.wall_type)
);
`default_nettype wire

// ===== dv/tb_grid_ray_cast_dda_core.sv =====
// Self-checking testbench for the grid ray caster: map loads, casts and camera settings.
`default_nettype none
module tb_grid_ray_cast_dda_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [20:0] cfg_data_i;

  grc_in_if  in_if ();
  grc_out_if out_if ();

  grid_ray_cast_dda_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if.sink),
    .out_if     (out_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the camera registers and the map.
  longint    pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, scr_cols, scr_rows;
  logic [7:0] wall_map [grc_pkg::MAP_DIM*grc_pkg::MAP_DIM];

  grc_pkg::out_beat_t column_q[$];
  int        errors;
  int        n_casts, n_writes, n_escapes, n_phases;
  bit        idle_on;
  int        stall_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint floor_q16(longint v);
    return (v >= 0) ? v / 65536 : -((-v + 65535) / 65536);
  endfunction

  function automatic longint ray_delta(longint r);
    if (r == 0) return longint'(1) << 40;
    return (longint'(1) << 32) / ((r < 0) ? -r : r);
  endfunction

  function automatic grc_pkg::out_beat_t predict_cast(logic [9:0] col);
    longint cols, rows, cam, rx, ry, cx, cy, sx, sy, px, py, hx, hy;
    longint dx, dy, sdx, sdy, perp, lh, half, ds, de, fx, fy;
    int     wall, side, esc;
    grc_pkg::out_beat_t o;
    cols = (scr_cols == 0) ? 1 : scr_cols;
    rows = (scr_rows == 0) ? 1 : scr_rows;
    perp = 0; wall = 0; side = 0; esc = 0;
    cam = (longint'(col) * 2 * 65536) / cols - 65536;
    rx = dir_x + floor_q16(plane_x * cam);
    ry = dir_y + floor_q16(plane_y * cam);
    cx = pos_x >>> 16;
    cy = pos_y >>> 16;
    hx = cx;
    hy = cy;
    if (cx >= grc_pkg::MAP_DIM || cy >= grc_pkg::MAP_DIM) begin
      esc = 1;
    end else begin
      dx = ray_delta(rx);
      dy = ray_delta(ry);
      fx = pos_x & 16'hFFFF;
      fy = pos_y & 16'hFFFF;
      sdx = (((rx < 0) ? fx : 65536 - fx) * dx) >>> 16;
      sdy = (((ry < 0) ? fy : 65536 - fy) * dy) >>> 16;
      sx = (rx < 0) ? -1 : 1;
      sy = (ry < 0) ? -1 : 1;
      for (int n = 0; n < grc_pkg::MAX_STEPS; n++) begin
        px = cx;
        py = cy;
        if (sdx < sdy) begin
          sdx += dx; cx += sx; side = 0; perp = sdx - dx;
        end else begin
          sdy += dy; cy += sy; side = 1; perp = sdy - dy;
        end
        if (cx < 0 || cx >= grc_pkg::MAP_DIM || cy < 0 || cy >= grc_pkg::MAP_DIM) begin
          esc = 1; hx = px; hy = py;
          break;
        end
        hx = cx;
        hy = cy;
        wall = wall_map[cy*grc_pkg::MAP_DIM + cx];
        if (wall != 0) break;
      end
    end
    if (perp > 24'hFFFFFF) perp = 24'hFFFFFF;
    half = rows / 2;
    lh = (perp == 0) ? 2 * rows + 2 : (rows << 16) / perp;
    ds = half - lh / 2;
    if (ds < 0) ds = 0;
    de = half + lh / 2;
    if (de >= rows) de = rows - 1;
    if (de > 1023) de = 1023;
    if (ds > 1023) ds = 1023;
    o.column_out = col;
    o.draw_start = ds[9:0];
    o.draw_end   = de[9:0];
    o.wall_type  = wall[7:0];
    o.hit_side   = side[0];
    o.hit_x      = hx[4:0];
    o.hit_y      = hy[4:0];
    o.perp_dist  = perp[23:0];
    o.escaped    = esc[0];
    return o;
  endfunction

  // Result checker: every result beat is matched against the oldest prediction.
  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    grc_pkg::out_beat_t want, got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (column_q.size() == 0) begin
        $error("result for column %0d with nothing expected", got.column_out);
        errors++;
      end else begin
        want = column_q.pop_front();
        check_field("column_out", want.column_out, got.column_out);
        check_field("draw_start", want.draw_start, got.draw_start);
        check_field("draw_end", want.draw_end, got.draw_end);
        check_field("wall_type", want.wall_type, got.wall_type);
        check_field("hit_side", want.hit_side, got.hit_side);
        check_field("hit_x", want.hit_x, got.hit_x);
        check_field("hit_y", want.hit_y, got.hit_y);
        check_field("perp_dist", want.perp_dist, got.perp_dist);
        check_field("escaped", want.escaped, got.escaped);
        if (want.escaped) n_escapes++;
      end
    end
  end

  always @(posedge clk_i) begin : result_stall
    int gap;
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      gap = pick_gap();
      out_if.ready <= (gap == 0);
      if (gap > 0) stall_left = gap - 1;
    end
  end

  // Drives one beat; valid stays high on return when no gap follows.
  task automatic send_beat(grc_pkg::in_beat_t b);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (b.func == grc_pkg::FUNC_WRITE) begin
      wall_map[b.cell_y*grc_pkg::MAP_DIM + b.cell_x] = b.cell_value;
      n_writes++;
    end else begin
      column_q.push_back(predict_cast(b.column));
      n_casts++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_cell(int x, int y, int v);
    grc_pkg::in_beat_t b;
    b = '0;
    b.func = grc_pkg::FUNC_WRITE;
    b.cell_x = x[4:0];
    b.cell_y = y[4:0];
    b.cell_value = v[7:0];
    b.column = 10'($urandom);
    send_beat(b);
  endtask

  task automatic cast_column(int col);
    grc_pkg::in_beat_t b;
    b = grc_pkg::in_beat_t'($bits(grc_pkg::in_beat_t)'($urandom));
    b.func = grc_pkg::FUNC_CAST;
    b.column = col[9:0];
    send_beat(b);
  endtask

  // Stops sending and waits until every predicted result has arrived or a guard runs out.
  task automatic drain();
    int guard;
    in_if.valid <= 1'b0;
    guard = 0;
    while (column_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [2:0] idx, longint v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v[20:0];
    case (idx)
      grc_pkg::REG_POS_X:   pos_x = v & 21'h1FFFFF;
      grc_pkg::REG_POS_Y:   pos_y = v & 21'h1FFFFF;
      grc_pkg::REG_DIR_X:   dir_x = v;
      grc_pkg::REG_DIR_Y:   dir_y = v;
      grc_pkg::REG_PLANE_X: plane_x = v;
      grc_pkg::REG_PLANE_Y: plane_y = v;
      grc_pkg::REG_COLS:    scr_cols = v & 11'h7FF;
      grc_pkg::REG_ROWS:    scr_rows = v & 11'h7FF;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_camera(longint px, longint py, longint ddx, longint ddy,
                            longint plx, longint ply, longint c, longint r);
    drain();
    set_reg(grc_pkg::REG_POS_X, px);
    set_reg(grc_pkg::REG_POS_Y, py);
    set_reg(grc_pkg::REG_DIR_X, ddx);
    set_reg(grc_pkg::REG_DIR_Y, ddy);
    set_reg(grc_pkg::REG_PLANE_X, plx);
    set_reg(grc_pkg::REG_PLANE_Y, ply);
    set_reg(grc_pkg::REG_COLS, c);
    set_reg(grc_pkg::REG_ROWS, r);
    n_phases++;
  endtask

  // Every cell is written before any cast: walls on most of the border, sparse inside.
  task automatic test_map_load();
    bit edge_cell;
    for (int y = 0; y < grc_pkg::MAP_DIM; y++) begin
      for (int x = 0; x < grc_pkg::MAP_DIM; x++) begin
        edge_cell = (x == 0 || y == 0 || x == grc_pkg::MAP_DIM-1 || y == grc_pkg::MAP_DIM-1);
        if (edge_cell)
          write_cell(x, y, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255));
        else
          write_cell(x, y, ($urandom_range(0, 6) == 0) ? $urandom_range(1, 255) : 0);
      end
    end
  endtask

  task automatic test_directed_casts();
    // Reset camera: first, middle, last and out-of-range columns.
    cast_column(0);
    cast_column(369);
    cast_column(739);
    cast_column(740);
    cast_column(1023);
    write_cell(5, 3, 255);
    write_cell(6, 3, 1);
    write_cell(31, 31, 255);
    // Camera on a cell corner looking along an axis; the view toward -y gives zero distance.
    set_camera(3 << 16, 3 << 16, 65536, 0, 0, 0, 1024, 1024);
    cast_column(0);
    cast_column(512);
    cast_column(1023);
    set_camera(3 << 16, 3 << 16, 0, -65536, 0, 0, 0, 0);
    cast_column(0);
    cast_column(1023);
    // Camera in a corner cell with extreme vectors.
    set_camera(0, 0, -131072, -131072, 131071, -131072, 1, 1);
    cast_column(0);
    cast_column(1);
    set_camera(2097151, 2097151, 131071, 131071, -131072, 131071, 2, 1024);
    cast_column(0);
    cast_column(1);
    cast_column(1023);
    // Clear two border cells so some rays escape.
    set_camera((16 << 16) + 32768, (16 << 16) + 1, 0, 65536, 43254, 0, 740, 580);
    write_cell(16, 31, 0);
    write_cell(17, 31, 0);
    cast_column(370);
    cast_column(400);
  endtask

  task automatic test_random(int phases, int per_phase);
    longint c;
    for (int p = 0; p < phases; p++) begin
      c = (p % 4 == 0) ? 1024 : $urandom_range(1, 800);
      idle_on = (p % 3 != 0);
      set_camera($urandom_range(1 << 16, (31 << 16) - 1), $urandom_range(1 << 16, (31 << 16) - 1),
                 longint'($urandom_range(0, 262143)) - 131072,
                 longint'($urandom_range(0, 262143)) - 131072,
                 longint'($urandom_range(0, 262143)) - 131072,
                 longint'($urandom_range(0, 262143)) - 131072,
                 c, (p % 5 == 0) ? 1024 : $urandom_range(1, 1024));
      for (int i = 0; i < per_phase; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: write_cell($urandom_range(0, 31), $urandom_range(0, 31),
                                 ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 255));
          4, 5:    cast_column($urandom_range(0, 1023));
          default: cast_column($urandom_range(0, c - 1));
        endcase
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    errors = 0; n_casts = 0; n_writes = 0; n_escapes = 0; n_phases = 0;
    stall_left = 0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = grc_pkg::REG_POS_X;
    cfg_data_i = '0;
    pos_x = 229376; pos_y = 229376;
    dir_x = 65536; dir_y = 0;
    plane_x = 0; plane_y = 43254;
    scr_cols = 740; scr_rows = 580;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_map_load();
    test_directed_casts();
    test_random(8, 80);
    drain();
    $display("Covered %0d casts (%0d escaped) and %0d map writes over %0d camera settings.",
             n_casts, n_escapes, n_writes, n_phases);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/grc_pkg.sv
sv/grc_if.sv
sv/grc_div.sv
sv/grc_map_ram.sv
sv/grid_ray_cast_dda_core.sv
sv/grc_checker.sv
dv/tb_grid_ray_cast_dda_core.sv
